// ----- hw/rtl/dpst_pkg.sv -----
// package for the doppler pitch slew tracker
// constants, sequencer state type and widths; no dependencies
package dpst_pkg;

  localparam int unsigned FieldW = 24;
  localparam int unsigned SqW    = 50;   // sum of two squares of 25 bit values
  localparam int unsigned RadW   = 64;   // radicand s << 14
  localparam int unsigned RootW  = 32;
  localparam int unsigned NumW   = 43;   // c << 12, c = speed << 7
  localparam int unsigned DenW   = 34;   // signed denominator
  localparam int unsigned TrkW   = 24;

  localparam logic signed [TrkW-1:0] TrkMax   = 24'sh7fffff;
  localparam logic signed [TrkW-1:0] TrkReset = 24'sd4096;
  localparam logic signed [TrkW+1:0] Slew     = 26'sd819;
  localparam logic [14:0] OutLo = 15'd409;
  localparam logic [14:0] OutHi = 15'd16384;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_DIV,
    ST_UPD,
    ST_OUT
  } dpst_state_t;

endpackage

// ----- hw/rtl/dpst_sqrt.sv -----
// bit-serial integer square root, one result bit per cycle
// depends on dpst_pkg
module dpst_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [dpst_pkg::RadW-1:0]  rad,
  output logic                       done,
  output logic [dpst_pkg::RootW-1:0] root
);
  import dpst_pkg::*;

  localparam int unsigned RemW = RootW + 2;

  logic [RadW-1:0]    val;
  logic [RemW-1:0]    rem;
  logic [RootW-1:0]   res;
  logic [5:0]         cnt;
  logic               busy;
  logic [RemW:0]      rem_sh;
  logic [RemW:0]      trial;
  logic               take;

  // restoring method: bring down two bits, try 4r+1
  always_comb begin
    rem_sh = {rem[RootW:0], val[RadW-1 -: 2]};
    trial  = {1'b0, res, 2'b01};
    take   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        val  <= rad;
        rem  <= '0;
        res  <= '0;
      end else if (busy) begin
        val <= {val[RadW-3:0], 2'b00};
        rem <= RemW'(take ? rem_sh - trial : rem_sh);
        res <= {res[RootW-2:0], take};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(RootW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = res;
endmodule

// ----- hw/rtl/doppler_pitch_slew_tracker_unit.sv -----
// doppler pitch slew tracker: one item at a time, radix-4 serial squares, bit-serial
// roots and divide. from input transfer to result valid: two passes of squaring and
// root, then divide and tracker update; the divide is skipped when the source closes
// in at sound speed or faster. the next item is taken in the cycle after the result
// transfer. reset: tracker 1.0, sound speed 1.0, idle.
// depends on dpst_pkg and dpst_sqrt
module doppler_pitch_slew_tracker_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_z,
  input  logic signed [23:0] vel_x,
  input  logic signed [23:0] vel_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] pitch_factor,
  output logic        was_clamped,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data
);
  import dpst_pkg::*;

  dpst_state_t state, state_next;

  logic [23:0] sound_speed;
  logic signed [TrkW-1:0] trk;

  logic signed [24:0] ax0, az0, ax1, az1;
  logic [24:0] mx, mz;          // magnitudes being squared
  logic [24:0] mpx, mpz;        // multiplier shift registers
  logic [24:0] m1x, m1z;        // magnitudes of the next position
  logic [SqW-1:0] acc;
  logic [4:0] cnt;
  logic       pass;             // 0: now, 1: next
  logic [RootW-1:0] d0;

  logic sq_start, sq_done;
  logic [RootW-1:0] root;
  logic [SqW-1:0] rad_src;

  logic [NumW-1:0] num;
  logic [NumW-1:0] quo;
  logic [DenW-1:0] den;
  logic [DenW-1:0] drem;
  logic [5:0] dcnt;
  logic       sat;
  logic [DenW:0] drem_sh;

  always_ff @(posedge clk) begin
    if (rst) sound_speed <= 24'd256;
    else if (cfg_valid && cfg_ready) sound_speed <= cfg_data;
  end
  assign cfg_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_SQ;
      ST_SQ:   if (cnt == 5'd12) state_next = ST_ROOT;
      ST_ROOT: if (sq_done) state_next = pass ? ST_DIV : ST_SQ;
      ST_DIV:  if (sat || dcnt == 6'(NumW)) state_next = ST_UPD;
      ST_UPD:  state_next = ST_OUT;
      ST_OUT:  if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE);
    out_valid = (state == ST_OUT);
  end

  always_comb begin
    ax0 = {pos_x[23], pos_x};
    az0 = {pos_z[23], pos_z};
    ax1 = 25'(ax0 + {vel_x[23], vel_x});
    az1 = 25'(az0 + {vel_z[23], vel_z});
  end

  // two-bit radix multiplier step for both squares
  logic [SqW-1:0] pp;
  always_comb begin
    pp = (mpx[0] ? SqW'(mx) : '0) + (mpx[1] ? SqW'({mx, 1'b0}) : '0)
       + (mpz[0] ? SqW'(mz) : '0) + (mpz[1] ? SqW'({mz, 1'b0}) : '0);
  end

  // sum including the current digit; complete at the last digit
  assign rad_src  = acc + (pp << {cnt, 1'b0});
  assign sq_start = (state == ST_SQ) && (cnt == 5'd12);

  dpst_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .start(sq_start),
    .rad  ({rad_src, 14'd0}),
    .done (sq_done),
    .root (root)
  );

  assign drem_sh = {drem, num[NumW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      trk   <= TrkReset;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: if (in_valid) begin
          mx   <= ax0[24] ? 25'(-ax0) : ax0;
          mz   <= az0[24] ? 25'(-az0) : az0;
          mpx  <= ax0[24] ? 25'(-ax0) : ax0;
          mpz  <= az0[24] ? 25'(-az0) : az0;
          m1x  <= ax1[24] ? 25'(-ax1) : ax1;
          m1z  <= az1[24] ? 25'(-az1) : az1;
          acc  <= '0;
          cnt  <= '0;
          pass <= 1'b0;
        end
        ST_SQ: if (cnt != 5'd12) begin
          // lsb-first with shifted partial products
          acc <= rad_src;
          mpx <= mpx >> 2;
          mpz <= mpz >> 2;
          cnt <= cnt + 5'd1;
        end
        ST_ROOT: if (sq_done) begin
          if (!pass) begin
            d0   <= root;
            pass <= 1'b1;
            mx   <= m1x;
            mz   <= m1z;
            mpx  <= m1x;
            mpz  <= m1z;
            acc  <= '0;
            cnt  <= '0;
          end else begin
            den  <= DenW'({sound_speed, 7'd0}) - DenW'(d0) + DenW'(root);
            num  <= {sound_speed, 19'd0};
            sat  <= 1'b0;
            drem <= '0;
            quo  <= '0;
            dcnt <= '0;
            if ($signed(DenW'({sound_speed, 7'd0}) - DenW'(d0) + DenW'(root)) <= 0)
              sat <= 1'b1;
          end
        end
        ST_DIV: if (!sat && dcnt != 6'(NumW)) begin
          if (drem_sh >= {1'b0, den}) begin
            drem <= DenW'(drem_sh - {1'b0, den});
            quo  <= {quo[NumW-2:0], 1'b1};
          end else begin
            drem <= DenW'(drem_sh);
            quo  <= {quo[NumW-2:0], 1'b0};
          end
          num  <= {num[NumW-2:0], 1'b0};
          dcnt <= dcnt + 6'd1;
        end
        ST_UPD: begin
          logic signed [TrkW+1:0] tgt, diff, nt;
          tgt  = (sat || quo > NumW'(TrkMax)) ? 26'(TrkMax) : 26'(quo);
          diff = tgt - 26'(trk);
          if (diff > Slew) nt = 26'(trk) + Slew;
          else if (diff < -Slew) nt = 26'(trk) - Slew;
          else nt = tgt;
          if (nt > 26'(TrkMax)) nt = 26'(TrkMax);
          if (nt < -26'sd8388608) nt = -26'sd8388608;
          trk <= TrkW'(nt);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (trk > $signed({9'd0, OutHi})) begin
      pitch_factor = OutHi;
      was_clamped  = 1'b1;
    end else if (trk < $signed({9'd0, OutLo})) begin
      pitch_factor = OutLo;
      was_clamped  = 1'b1;
    end else begin
      pitch_factor = trk[14:0];
      was_clamped  = 1'b0;
    end
  end

endmodule
